>>> hw/rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned BYTES_W    = 17;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned ALIGN_MASK = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_NULL   = 3'd1,
    ST_NOFIT  = 3'd2,
    ST_BADPTR = 3'd3,
    ST_DOUBLE = 3'd4
  } status_e;

  // table read address source
  typedef enum logic [1:0] {
    RD_IDX      = 2'd0,
    RD_IDX_NEXT = 2'd1,
    RD_J_PREV   = 2'd2,
    RD_J        = 2'd3
  } rd_sel_e;

  // table write address/data source
  typedef enum logic [2:0] {
    WR_SHIFT_UP = 3'd0,
    WR_REMAIN   = 3'd1,
    WR_HEAD     = 3'd2,
    WR_USED     = 3'd3,
    WR_MERGED   = 3'd4,
    WR_SHIFT_DN = 3'd5
  } wr_sel_e;

  typedef struct packed {
    logic    capture;
    logic    scan_start;
    logic    scan_adv;
    logic    take_cur;
    logic    take_next;
    logic    clear_next;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    j_from_count;
    logic    j_dec;
    logic    j_from_merge;
    logic    j_inc;
    logic    set_status;
    status_e status;
    logic    st_whole;
    logic    st_split;
    logic    st_free;
    logic    st_shrink;
    logic    set_payload;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic act;
    logic req_zero;
    logic addr_null;
    logic off_bad;
    logic at_end;
    logic fits;
    logic split_ok;
    logic match;
    logic ent_free;
    logic has_next;
    logic shift_more;
    logic merge_more;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/ffba_table.sv
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one registered read port. Entry 0
// reads as its reset value until first written.
// ----------------------------------------------------------------------------
module ffba_table #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 18,
  parameter logic [WIDTH-1:0] INIT0 = '0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic             v0_q;
  logic             rd_init_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      rd_init_q <= 1'b0;
    end else begin
      if (wr_en_i && (waddr_i == AW'(0))) begin
        v0_q <= 1'b1;
      end
      if (rd_en_i) begin
        rd_init_q <= (raddr_i == AW'(0)) && !v0_q;
      end
    end
  end

  assign rdata_o = rd_init_q ? INIT0 : rdata_q;

endmodule

>>> hw/rtl/ffba_datapath.sv
// ----------------------------------------------------------------------------
// ffba_datapath
// Request decode, table scan registers, shift/merge addressing, heap
// statistics and the result register.
// ----------------------------------------------------------------------------
module ffba_datapath
  import ffba_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned MIN_BLOCK    = 32,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ADDR_W-1:0]   heap_base_i,
  input  logic                action_i,
  input  logic [ADDR_W-1:0]   request_bytes_i,
  input  logic [ADDR_W-1:0]   address_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [ADDR_W-1:0]   payload_address_o,
  output logic [BYTES_W-1:0]  used_bytes_o,
  output logic [BYTES_W-1:0]  free_bytes_o,
  output logic [CNT_W-1:0]    block_count_o,
  output logic [CNT_W-1:0]    free_block_count_o
);

  localparam int unsigned SW = $clog2(HEAP_BYTES + 1);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned EW = SW + 1;
  localparam int unsigned TW = ADDR_W + 2;
  localparam logic [SW-1:0] HEAP_SZ = SW'(HEAP_BYTES);
  localparam logic [SW-1:0] MIN_SZ  = SW'(MIN_BLOCK);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

  // request decode
  logic [TW-1:0]     req_rnd, req_tot, req_min;
  logic              req_big;
  logic [ADDR_W-1:0] free_off;

  assign req_rnd  = (TW'(request_bytes_i) + TW'(ALIGN_MASK)) & ~TW'(ALIGN_MASK);
  assign req_tot  = req_rnd + TW'(HEADER_BYTES);
  assign req_big  = req_tot > TW'(HEAP_BYTES);
  assign req_min  = (req_tot < TW'(MIN_BLOCK)) ? TW'(MIN_BLOCK) : req_tot;
  assign free_off = address_i - ADDR_W'(HEADER_BYTES) - heap_base_i;

  logic              act_q, req_zero_q, addr_null_q, off_bad_q, big_q;
  logic [SW-1:0]     total_q;
  logic [ADDR_W-1:0] off_q;

  // scan state
  logic [CW-1:0] idx_q, j_q;
  logic [SW-1:0] acc_q, cur_q, prev_size_q, next_size_q;
  logic          prev_free_q, next_free_q;

  // heap statistics
  logic [CW-1:0] count_q, nfree_q;
  logic [SW-1:0] free_bytes_q;

  // result
  status_e           status_q, out_status_q;
  logic [ADDR_W-1:0] payload_q, out_payload_q;
  logic [BYTES_W-1:0] out_used_q, out_free_q;
  logic [CNT_W-1:0]  out_count_q, out_nfree_q;
  logic              out_valid_q;

  // table
  logic [EW-1:0] rdata, wdata;
  logic [CW-1:0] raddr, waddr;
  logic [SW-1:0] ent_size;
  logic          ent_free;

  assign ent_free = rdata[SW];
  assign ent_size = rdata[SW-1:0];

  // merge geometry
  logic [1:0]    mrg_n;
  logic [CW-1:0] mrg_base;
  logic [SW-1:0] mrg_size;

  assign mrg_n    = {1'b0, prev_free_q} + {1'b0, next_free_q};
  assign mrg_base = prev_free_q ? (idx_q - CW'(1)) : idx_q;
  assign mrg_size = cur_q + (prev_free_q ? prev_size_q : '0)
                  + (next_free_q ? next_size_q : '0);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_IDX:      raddr = idx_q;
      RD_IDX_NEXT: raddr = idx_q + CW'(1);
      RD_J_PREV:   raddr = j_q - CW'(1);
      RD_J:        raddr = j_q;
      default:     raddr = idx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_SHIFT_UP: begin
        waddr = j_q;
        wdata = rdata;
      end
      WR_REMAIN: begin
        waddr = idx_q + CW'(1);
        wdata = {1'b1, cur_q - total_q};
      end
      WR_HEAD: begin
        waddr = idx_q;
        wdata = {1'b0, total_q};
      end
      WR_USED: begin
        waddr = idx_q;
        wdata = {1'b0, ent_size};
      end
      WR_MERGED: begin
        waddr = mrg_base;
        wdata = {1'b1, mrg_size};
      end
      WR_SHIFT_DN: begin
        waddr = j_q - CW'(mrg_n);
        wdata = rdata;
      end
      default: begin
        waddr = idx_q;
        wdata = rdata;
      end
    endcase
  end

  ffba_table #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (EW),
    .INIT0 ({1'b1, HEAP_SZ})
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cmd_i.wr_en),
    .waddr_i (waddr[IW-1:0]),
    .wdata_i (wdata),
    .rd_en_i (cmd_i.rd_en),
    .raddr_i (raddr[IW-1:0]),
    .rdata_o (rdata)
  );

  // status toward the controller
  always_comb begin
    sts_o.act        = act_q;
    sts_o.req_zero   = req_zero_q;
    sts_o.addr_null  = addr_null_q;
    sts_o.off_bad    = off_bad_q;
    sts_o.at_end     = (idx_q == count_q);
    sts_o.fits       = ent_free && !big_q && (ent_size >= total_q);
    sts_o.split_ok   = ({1'b0, ent_size} >= ({1'b0, total_q} + {1'b0, MIN_SZ}))
                     && (count_q < MAX_CNT);
    sts_o.match      = (ADDR_W'(acc_q) == off_q);
    sts_o.ent_free   = ent_free;
    sts_o.has_next   = (({1'b0, idx_q} + (CW+1)'(1)) < {1'b0, count_q});
    sts_o.shift_more = ({1'b0, j_q} > ({1'b0, idx_q} + (CW+1)'(1)));
    sts_o.merge_more = (j_q < count_q);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q       <= action_i;
      req_zero_q  <= (request_bytes_i == '0);
      addr_null_q <= (address_i == '0);
      off_bad_q   <= ((ADDR_W+1)'(free_off) >= (ADDR_W+1)'(HEAP_BYTES));
      big_q       <= req_big;
      total_q     <= SW'(req_min);
      off_q       <= free_off;
      payload_q   <= '0;
    end
    if (cmd_i.scan_start) begin
      idx_q       <= '0;
      acc_q       <= '0;
      prev_free_q <= 1'b0;
    end
    if (cmd_i.scan_adv) begin
      idx_q       <= idx_q + CW'(1);
      acc_q       <= acc_q + ent_size;
      prev_size_q <= ent_size;
      prev_free_q <= ent_free;
    end
    if (cmd_i.take_cur) begin
      cur_q <= ent_size;
    end
    if (cmd_i.take_next) begin
      next_size_q <= ent_size;
      next_free_q <= ent_free;
    end
    if (cmd_i.clear_next) begin
      next_free_q <= 1'b0;
    end
    if (cmd_i.j_from_count) begin
      j_q <= count_q;
    end
    if (cmd_i.j_dec) begin
      j_q <= j_q - CW'(1);
    end
    if (cmd_i.j_from_merge) begin
      j_q <= mrg_base + CW'(1) + CW'(mrg_n);
    end
    if (cmd_i.j_inc) begin
      j_q <= j_q + CW'(1);
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.set_payload) begin
      payload_q <= heap_base_i + ADDR_W'(acc_q) + ADDR_W'(HEADER_BYTES);
    end
    if (cmd_i.out_load) begin
      out_status_q  <= status_q;
      out_payload_q <= payload_q;
      out_used_q    <= BYTES_W'(HEAP_SZ - free_bytes_q);
      out_free_q    <= BYTES_W'(free_bytes_q);
      out_count_q   <= CNT_W'(count_q);
      out_nfree_q   <= CNT_W'(nfree_q);
    end
  end

  // heap statistics and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= CW'(1);
      nfree_q      <= CW'(1);
      free_bytes_q <= HEAP_SZ;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.st_whole) begin
        free_bytes_q <= free_bytes_q - ent_size;
        nfree_q      <= nfree_q - CW'(1);
      end
      if (cmd_i.st_split) begin
        free_bytes_q <= free_bytes_q - total_q;
        count_q      <= count_q + CW'(1);
      end
      if (cmd_i.st_free) begin
        free_bytes_q <= free_bytes_q + cur_q;
        nfree_q      <= nfree_q + CW'(1) - CW'(mrg_n);
      end
      if (cmd_i.st_shrink) begin
        count_q <= count_q - CW'(mrg_n);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign payload_address_o  = out_payload_q;
  assign used_bytes_o       = out_used_q;
  assign free_bytes_o       = out_free_q;
  assign block_count_o      = out_count_q;
  assign free_block_count_o = out_nfree_q;

endmodule

>>> hw/rtl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: table scan, split shift-up, free merge and shift-down.
// ----------------------------------------------------------------------------
module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_DISP   = 17'h00002,
    S_A_RD   = 17'h00004,
    S_A_CHK  = 17'h00008,
    S_SH_RD  = 17'h00010,
    S_SH_WR  = 17'h00020,
    S_REM    = 17'h00040,
    S_HEAD   = 17'h00080,
    S_F_RD   = 17'h00100,
    S_F_CHK  = 17'h00200,
    S_N_RD   = 17'h00400,
    S_N_CHK  = 17'h00800,
    S_M_WR   = 17'h01000,
    S_M_RD   = 17'h02000,
    S_M_SH   = 17'h04000,
    S_FIN    = 17'h08000,
    S_SPARE  = 17'h10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.set_status = 1'b1;
        if (!sts_i.act) begin
          if (sts_i.req_zero) begin
            cmd_o.status = ST_NULL;
            state_d      = S_FIN;
          end else begin
            cmd_o.set_status = 1'b0;
            cmd_o.scan_start = 1'b1;
            state_d          = S_A_RD;
          end
        end else if (sts_i.addr_null) begin
          cmd_o.status = ST_NULL;
          state_d      = S_FIN;
        end else if (sts_i.off_bad) begin
          cmd_o.status = ST_BADPTR;
          state_d      = S_FIN;
        end else begin
          cmd_o.set_status = 1'b0;
          cmd_o.scan_start = 1'b1;
          state_d          = S_F_RD;
        end
      end
      S_A_RD: begin
        if (sts_i.at_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOFIT;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (sts_i.fits) begin
          cmd_o.take_cur = 1'b1;
          if (sts_i.split_ok) begin
            cmd_o.j_from_count = 1'b1;
            state_d            = S_SH_RD;
          end else begin
            cmd_o.wr_en       = 1'b1;
            cmd_o.wr_sel      = WR_USED;
            cmd_o.st_whole    = 1'b1;
            cmd_o.set_payload = 1'b1;
            cmd_o.set_status  = 1'b1;
            cmd_o.status      = ST_OK;
            state_d           = S_FIN;
          end
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = S_A_RD;
        end
      end
      S_SH_RD: begin
        if (sts_i.shift_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_J_PREV;
          state_d      = S_SH_WR;
        end else begin
          state_d = S_REM;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHIFT_UP;
        cmd_o.j_dec  = 1'b1;
        state_d      = S_SH_RD;
      end
      S_REM: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_REMAIN;
        state_d      = S_HEAD;
      end
      S_HEAD: begin
        cmd_o.wr_en       = 1'b1;
        cmd_o.wr_sel      = WR_HEAD;
        cmd_o.st_split    = 1'b1;
        cmd_o.set_payload = 1'b1;
        cmd_o.set_status  = 1'b1;
        cmd_o.status      = ST_OK;
        state_d           = S_FIN;
      end
      S_F_RD: begin
        if (sts_i.at_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_BADPTR;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (sts_i.match) begin
          if (sts_i.ent_free) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_DOUBLE;
            state_d          = S_FIN;
          end else begin
            cmd_o.take_cur = 1'b1;
            state_d        = S_N_RD;
          end
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = S_F_RD;
        end
      end
      S_N_RD: begin
        if (sts_i.has_next) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_NEXT;
          state_d      = S_N_CHK;
        end else begin
          cmd_o.clear_next = 1'b1;
          state_d          = S_M_WR;
        end
      end
      S_N_CHK: begin
        cmd_o.take_next = 1'b1;
        state_d         = S_M_WR;
      end
      S_M_WR: begin
        cmd_o.wr_en        = 1'b1;
        cmd_o.wr_sel       = WR_MERGED;
        cmd_o.st_free      = 1'b1;
        cmd_o.j_from_merge = 1'b1;
        state_d            = S_M_RD;
      end
      S_M_RD: begin
        if (sts_i.merge_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_J;
          state_d      = S_M_SH;
        end else begin
          cmd_o.st_shrink  = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_OK;
          state_d          = S_FIN;
        end
      end
      S_M_SH: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHIFT_DN;
        cmd_o.j_inc  = 1'b1;
        state_d      = S_M_RD;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> hw/rtl/first_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit heap allocator with block split on allocate and neighbor
// coalescing on free, over an address-ordered block table.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  request  | in        | in_valid_i/in_stall_o| action, request_bytes, address
//  result   | out       | out_valid_o/out_stall_i | status, payload_address,
//           |           |                      | used/free bytes, block counts
//  config   | in        | APB psel/penable     | heap_base at byte address 0
//
//  Work: an allocate scans blocks and shifts entries up on a split; a free
//  scans blocks and shifts entries down after a merge. The table memory
//  gives one write and one registered read per cycle.
//  Reset: one table entry holding the whole free heap; no clearing pass,
//  entry 0 reads as the full heap until first written.
//  Stalls: the result register holds a finished transfer while the next
//  request is already taken; a request only waits on it at its last step.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned MIN_BLOCK    = 32,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [ADDR_W-1:0]   request_bytes_i,
  input  logic [ADDR_W-1:0]   address_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [ADDR_W-1:0]   payload_address_o,
  output logic [BYTES_W-1:0]  used_bytes_o,
  output logic [BYTES_W-1:0]  free_bytes_o,
  output logic [CNT_W-1:0]    block_count_o,
  output logic [CNT_W-1:0]    free_block_count_o
);

  // heap base register; only word 0 is decoded, other words read as 0
  logic [ADDR_W-1:0] heap_base_q;
  logic              cfg_wr;
  logic              base_hit;

  assign pready   = 1'b1;
  assign base_hit = (paddr[2] == 1'b0);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = base_hit ? heap_base_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
    end else if (cfg_wr && base_hit) begin
      heap_base_q <= pwdata;
    end
  end

  cmd_t cmd;
  sts_t sts;

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffba_datapath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .MIN_BLOCK    (MIN_BLOCK),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .heap_base_i        (heap_base_q),
    .action_i           (action_i),
    .request_bytes_i    (request_bytes_i),
    .address_i          (address_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .status_o           (status_o),
    .payload_address_o  (payload_address_o),
    .used_bytes_o       (used_bytes_o),
    .free_bytes_o       (free_bytes_o),
    .block_count_o      (block_count_o),
    .free_block_count_o (free_block_count_o)
  );

  localparam logic [BYTES_W-1:0] HEAP_LO = BYTES_W'(HEAP_BYTES);

`ifndef SYNTH
  // used and free bytes always partition the heap
  a_bytes_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (BYTES_W'(used_bytes_o + free_bytes_o) == HEAP_LO))
    else $error("used plus free bytes differ from heap size");

  // free blocks never outnumber all blocks
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (free_block_count_o <= block_count_o))
    else $error("free block count above block count");

  // an accepted request keeps the input side busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request side free right after a transfer");
`endif

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit block allocator: a behavioral heap
// table predicts every result, random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench
  import ffba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP  = 65536;
  localparam int unsigned MINB  = 32;
  localparam int unsigned HDR   = 16;
  localparam int unsigned MAXB  = 64;
  localparam logic        ACT_ALLOC = 1'b0;
  localparam logic        ACT_FREE  = 1'b1;
  localparam logic [2:0]  REG_HEAP_BASE = 3'd0;

  typedef struct packed {
    status_e             status;
    logic [ADDR_W-1:0]   payload;
    logic [BYTES_W-1:0]  used;
    logic [BYTES_W-1:0]  freeb;
    logic [CNT_W-1:0]    nblk;
    logic [CNT_W-1:0]    nfree;
  } alloc_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic act = 1'b0;
  logic [31:0] req_bytes = '0, addr = '0;
  logic out_valid, out_stall = 1'b0;
  logic [2:0] st_o;
  logic [31:0] pay_o;
  logic [16:0] used_o, free_o;
  logic [6:0] nblk_o, nfree_o;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  first_fit_block_allocator_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .action_i(act),
    .request_bytes_i(req_bytes), .address_i(addr),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .status_o(st_o),
    .payload_address_o(pay_o), .used_bytes_o(used_o), .free_bytes_o(free_o),
    .block_count_o(nblk_o), .free_block_count_o(nfree_o)
  );

  // predictor state: mirror of the block table
  logic [31:0] heap_base_m = '0;
  logic [16:0] blk_size [MAXB];
  logic        blk_free [MAXB];
  int unsigned nblocks;
  alloc_res_t  expected_q [$];
  int unsigned errors = 0;
  // payload addresses currently handed out, used to build valid frees
  logic [31:0] live_ptrs [$];

  function automatic void table_reset();
    for (int i = 0; i < MAXB; i++) begin
      blk_size[i] = '0;
      blk_free[i] = 1'b0;
    end
    blk_size[0] = 17'(HEAP);
    blk_free[0] = 1'b1;
    nblocks = 1;
  endfunction

  // collapse every run of adjacent free blocks
  function automatic void coalesce();
    int unsigned i;
    i = 0;
    while (i + 1 < nblocks) begin
      if (blk_free[i] && blk_free[i+1]) begin
        blk_size[i] = blk_size[i] + blk_size[i+1];
        for (int unsigned k = i + 1; k + 1 < nblocks; k++) begin
          blk_size[k] = blk_size[k+1];
          blk_free[k] = blk_free[k+1];
        end
        nblocks--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic alloc_res_t predict_heap(logic a, logic [31:0] rq, logic [31:0] ad);
    alloc_res_t r;
    logic [33:0] need;
    logic [31:0] off, hdr;
    bit done;
    r = '0;
    done = 0;
    if (a == ACT_ALLOC) begin
      if (rq == 0) begin
        r.status = ST_NULL;
      end else begin
        need = ((34'(rq) + 34'(ALIGN_MASK)) & ~34'(ALIGN_MASK)) + 34'(HDR);
        if (need < 34'(MINB)) need = 34'(MINB);
        off = '0;
        r.status = ST_NOFIT;
        for (int unsigned i = 0; i < nblocks && !done; i++) begin
          if (blk_free[i] && 34'(blk_size[i]) >= need) begin
            if (34'(blk_size[i]) >= need + 34'(MINB) && nblocks < MAXB) begin
              for (int unsigned k = nblocks; k > i + 1; k--) begin
                blk_size[k] = blk_size[k-1];
                blk_free[k] = blk_free[k-1];
              end
              blk_size[i+1] = blk_size[i] - 17'(need);
              blk_free[i+1] = 1'b1;
              blk_size[i] = 17'(need);
              nblocks++;
            end
            blk_free[i] = 1'b0;
            r.status = ST_OK;
            r.payload = heap_base_m + off + 32'(HDR);
            done = 1;
          end else begin
            off = off + 32'(blk_size[i]);
          end
        end
      end
    end else if (ad == 0) begin
      r.status = ST_NULL;
    end else begin
      hdr = ad - 32'(HDR);
      off = hdr - heap_base_m;
      r.status = ST_BADPTR;
      if (off < HEAP) begin
        hdr = '0;
        for (int unsigned i = 0; i < nblocks && !done; i++) begin
          if (hdr == off) begin
            done = 1;
            if (blk_free[i]) r.status = ST_DOUBLE;
            else begin
              blk_free[i] = 1'b1;
              coalesce();
              r.status = ST_OK;
            end
          end
          hdr = hdr + 32'(blk_size[i]);
        end
      end
    end
    for (int unsigned i = 0; i < nblocks; i++) begin
      if (blk_free[i]) begin
        r.freeb += blk_size[i];
        r.nfree++;
      end else r.used += blk_size[i];
    end
    r.nblk = 7'(nblocks);
    return r;
  endfunction

  bit quiet_tx = 0, quiet_rx = 0;

  // result checker and receiver stalls
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    alloc_res_t e;
    if (out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer, status %0d", st_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (st_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, st_o); errors++;
        end
        if (pay_o !== e.payload) begin
          $error("payload_address expected %h actual %h", e.payload, pay_o); errors++;
        end
        if (used_o !== e.used) begin
          $error("used_bytes expected %0d actual %0d", e.used, used_o); errors++;
        end
        if (free_o !== e.freeb) begin
          $error("free_bytes expected %0d actual %0d", e.freeb, free_o); errors++;
        end
        if (nblk_o !== e.nblk) begin
          $error("block_count expected %0d actual %0d", e.nblk, nblk_o); errors++;
        end
        if (nfree_o !== e.nfree) begin
          $error("free_block_count expected %0d actual %0d", e.nfree, nfree_o); errors++;
        end
      end
      stall_left = quiet_rx ? 0 : $urandom_range(0, 15);
    end
    if (!rst_n) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else out_stall <= 1'b0;
  end

  // valid stays up between back-to-back items; it drops only for a gap or a drain
  task automatic send_request(logic a, logic [31:0] rq, logic [31:0] ad);
    alloc_res_t r;
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    act <= a;
    req_bytes <= rq;
    addr <= ad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer happened at this edge
    r = predict_heap(a, rq, ad);
    expected_q.push_back(r);
    if (a == ACT_ALLOC && r.status == ST_OK) live_ptrs.push_back(r.payload);
    if (a == ACT_FREE && r.status == ST_OK)
      foreach (live_ptrs[i]) if (live_ptrs[i] == ad) begin
        live_ptrs.delete(i);
        break;
      end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_heap_base(logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_HEAP_BASE; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    heap_base_m = v;
    @(posedge clk);
  endtask

  // free everything still live so the next phase starts from an empty heap
  task automatic release_all();
    while (live_ptrs.size() != 0) send_request(ACT_FREE, $urandom, live_ptrs[0]);
  endtask

  task automatic test_directed();
    logic [31:0] p;
    quiet_tx = 1;
    send_request(ACT_ALLOC, 32'd0, 32'd0);          // zero size
    send_request(ACT_FREE, 32'hFFFF_FFFF, 32'd0);   // null free
    send_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0);  // oversized, no wrap
    send_request(ACT_ALLOC, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
    send_request(ACT_ALLOC, 32'd1, 32'd0);          // raised to min block
    p = live_ptrs[0];
    send_request(ACT_ALLOC, 32'd13, 32'd0);
    send_request(ACT_FREE, 32'd0, p);
    send_request(ACT_FREE, 32'd0, p);               // double free
    send_request(ACT_FREE, 32'd0, p + 32'd4);       // names no block
    send_request(ACT_FREE, 32'd0, 32'hFFFF_FFFF);   // outside heap
    send_request(ACT_FREE, 32'd0, 32'd8);           // header below base wraps
    send_request(ACT_ALLOC, 32'(HEAP - HDR), 32'd0);// whole heap no fit now
    release_all();
    send_request(ACT_ALLOC, 32'(HEAP - HDR), 32'd0);// exact whole heap
    release_all();
    send_request(ACT_ALLOC, 32'(HEAP - HDR - MINB), 32'd0); // remainder = min
    release_all();
    quiet_tx = 0;
    drain();
  endtask

  // fill the table, then allocate from a block with no room to split
  task automatic test_full_table();
    for (int i = 0; i < MAXB + 2; i++) send_request(ACT_ALLOC, 32'd16, 32'd0);
    send_request(ACT_FREE, 32'd0, live_ptrs[3]);
    send_request(ACT_ALLOC, 32'd4, 32'd0);
    release_all();
    drain();
  endtask

  task automatic test_random(int unsigned n, logic [31:0] base);
    int unsigned k;
    logic [31:0] rq, ad;
    write_heap_base(base);
    for (int unsigned i = 0; i < n; i++) begin
      quiet_tx = ($urandom_range(0, 9) == 0);
      quiet_rx = ($urandom_range(0, 9) == 0);
      k = $urandom_range(0, 99);
      if (k < 50) begin
        rq = (k < 45) ? $urandom_range(1, 1500) : $urandom;
        send_request(ACT_ALLOC, rq, $urandom);
      end else if (k < 85 && live_ptrs.size() != 0) begin
        send_request(ACT_FREE, $urandom,
                     live_ptrs[$urandom_range(0, live_ptrs.size() - 1)]);
      end else begin
        ad = (k < 92) ? base + 32'(HDR) + ($urandom_range(0, HEAP) & ~32'd3) : $urandom;
        send_request(ACT_FREE, $urandom, ad);
      end
    end
    quiet_tx = 0; quiet_rx = 0;
    release_all();
    drain();
  endtask

  initial begin
    table_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(80, 32'h0000_1000);
    test_random(70, 32'hFFFF_8000);   // heap wraps past the top
    test_random(70, 32'hFFFF_FFFF);
    test_random(60, 32'h0000_0000);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_table.sv
hw/rtl/ffba_datapath.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/first_fit_block_allocator_unit.sv
sim/testbench.sv
